>>> rtl/vglm_pkg.sv
// ----------------------------------------------------------------------------
// vglm_pkg
// Shared constants and codes for the variable grid layout mapper.
// ----------------------------------------------------------------------------
package vglm_pkg;

    localparam int MAX_ROWS_DEF = 1024;
    localparam int MAX_COLS_DEF = 256;
    localparam int SIZE_W       = 16;

    localparam logic [10:0]       ROWS_RST    = 11'd100;
    localparam logic [8:0]        COLS_RST    = 9'd26;
    localparam logic [SIZE_W-1:0] ROW_SZ_RST  = 16'd384;
    localparam logic [SIZE_W-1:0] COL_SZ_RST  = 16'd1280;

    typedef enum logic [2:0] {
        ACT_SET_ROW = 3'd0,
        ACT_SET_COL = 3'd1,
        ACT_BOUNDS  = 3'd2,
        ACT_HIT     = 3'd3,
        ACT_EXTENT  = 3'd4
    } action_t;

    typedef enum logic [1:0] {
        REG_ROWS   = 2'd0,
        REG_COLS   = 2'd1,
        REG_ROW_SZ = 2'd2,
        REG_COL_SZ = 2'd3
    } reg_idx_t;

endpackage

>>> rtl/vglm_ram.sv
// ----------------------------------------------------------------------------
// vglm_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module vglm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/variable_grid_layout_mapper.sv
// ----------------------------------------------------------------------------
// variable_grid_layout_mapper
// Grid of rows and columns with per-index size overrides; cumulative edge
// tables rebuilt on demand; cell bounds, content extent and hit test.
// ----------------------------------------------------------------------------
//  channel   | signals                                      | handshake
//  ----------+----------------------------------------------+-----------------
//  command   | action row_index col_index size_value        | start & !busy
//            | point_x point_y                              |
//  result    | cell_x cell_y cell_width cell_height         | done, 1 cycle
//            | hit_row hit_col                              |
//  config    | wr_index wr_data                             | wr_en
//
//  After reset a clearing pass over the row and column size stores holds busy.
//  Sets and unknown actions: result the cycle after acceptance.
//  Bounds and extent: a read state, then an output state; a stale table adds a
//  rebuild first, one entry a cycle through the size and prefix memories.
//  Hit test: a column search, then a row search, one prefix entry read a cycle.
//  The result receiver cannot stall; done pulses for one cycle.
// ----------------------------------------------------------------------------
module variable_grid_layout_mapper
    import vglm_pkg::*;
#(
    parameter int MAX_ROWS = MAX_ROWS_DEF,
    parameter int MAX_COLS = MAX_COLS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  action,
    input  logic [10:0] row_index,
    input  logic [8:0]  col_index,
    input  logic [15:0] size_value,
    input  logic [23:0] point_x,
    input  logic [25:0] point_y,
    output logic        done,
    output logic [23:0] cell_x,
    output logic [25:0] cell_y,
    output logic [15:0] cell_width,
    output logic [15:0] cell_height,
    output logic [9:0]  hit_row,
    output logic [7:0]  hit_col,
    input  logic        wr_en,
    input  logic [1:0]  wr_index,
    input  logic [15:0] wr_data
);

    localparam int RA_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CA_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int RC_W  = $clog2(MAX_ROWS + 1);
    localparam int CC_W  = $clog2(MAX_COLS + 1);
    localparam int RP_W  = SIZE_W + $clog2(MAX_ROWS);
    localparam int CP_W  = SIZE_W + $clog2(MAX_COLS);
    localparam int MAXN  = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
    localparam int CNT_W = $clog2(MAXN + 1);
    localparam int ACC_W = (RP_W > CP_W) ? RP_W : CP_W;
    localparam int ST_W  = SIZE_W + 1;

    typedef enum logic [7:0] {
        ST_CLEAR   = 8'b0000_0001,
        ST_IDLE    = 8'b0000_0010,
        ST_RB_ROW  = 8'b0000_0100,
        ST_RB_COL  = 8'b0000_1000,
        ST_BND_RD  = 8'b0001_0000,
        ST_BND_OUT = 8'b0010_0000,
        ST_HIT_COL = 8'b0100_0000,
        ST_HIT_ROW = 8'b1000_0000
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic               pend_reg, pend_next;
    logic               found_reg, found_next;
    logic [ACC_W-1:0]   acc_reg, acc_next;
    logic               stale_reg, stale_next;
    logic [CC_W-1:0]    hc_reg, hc_next;
    logic [RC_W-1:0]    hr_reg, hr_next;

    logic [10:0]        rows_reg, rows_next;
    logic [8:0]         cols_reg, cols_next;
    logic [SIZE_W-1:0]  drow_reg, drow_next;
    logic [SIZE_W-1:0]  dcol_reg, dcol_next;

    logic [2:0]         act_reg, act_next;
    logic [10:0]        row_reg, row_next;
    logic [8:0]         col_reg, col_next;
    logic [23:0]        px_reg, px_next;
    logic [25:0]        py_reg, py_next;

    logic               done_reg, done_next;
    logic [23:0]        cx_reg, cx_next;
    logic [25:0]        cy_reg, cy_next;
    logic [15:0]        cw_reg, cw_next;
    logic [15:0]        ch_reg, ch_next;
    logic [9:0]         hrow_reg, hrow_next;
    logic [7:0]         hcol_reg, hcol_next;

    logic               rs_we, cs_we, rp_we, cp_we;
    logic [RA_W-1:0]    rs_waddr, rs_raddr;
    logic [CA_W-1:0]    cs_waddr, cs_raddr;
    logic [ST_W-1:0]    rs_wdata, cs_wdata, rs_rdata, cs_rdata;
    logic [RC_W-1:0]    rp_waddr, rp_raddr;
    logic [CC_W-1:0]    cp_waddr, cp_raddr;
    logic [RP_W-1:0]    rp_wdata, rp_rdata;
    logic [CP_W-1:0]    cp_wdata, cp_rdata;

    logic [RC_W-1:0]    n_r;
    logic [CC_W-1:0]    n_c;
    logic               row_lane;
    logic [CNT_W-1:0]   n_sel;
    logic               issue;
    logic [SIZE_W-1:0]  row_eff, col_eff;
    logic [RC_W-1:0]    row_pos;
    logic [CC_W-1:0]    col_pos;
    logic               accept;

    function automatic state_t query_entry(input logic [2:0] act);
        state_t s;
        s = ST_BND_RD;
        if (act == ACT_HIT)
        begin
            s = ST_HIT_COL;
        end
        return s;
    endfunction

    vglm_ram #(.WIDTH(ST_W), .DEPTH(MAX_ROWS)) u_row_store (
        .clk(clk), .we(rs_we), .waddr(rs_waddr), .wdata(rs_wdata),
        .raddr(rs_raddr), .rdata(rs_rdata)
    );

    vglm_ram #(.WIDTH(ST_W), .DEPTH(MAX_COLS)) u_col_store (
        .clk(clk), .we(cs_we), .waddr(cs_waddr), .wdata(cs_wdata),
        .raddr(cs_raddr), .rdata(cs_rdata)
    );

    vglm_ram #(.WIDTH(RP_W), .DEPTH(MAX_ROWS + 1)) u_row_pfx (
        .clk(clk), .we(rp_we), .waddr(rp_waddr), .wdata(rp_wdata),
        .raddr(rp_raddr), .rdata(rp_rdata)
    );

    vglm_ram #(.WIDTH(CP_W), .DEPTH(MAX_COLS + 1)) u_col_pfx (
        .clk(clk), .we(cp_we), .waddr(cp_waddr), .wdata(cp_wdata),
        .raddr(cp_raddr), .rdata(cp_rdata)
    );

    assign accept = start && (state_reg == ST_IDLE);
    assign n_r = (32'(rows_reg) > MAX_ROWS) ? RC_W'(MAX_ROWS) : RC_W'(rows_reg);
    assign n_c = (32'(cols_reg) > MAX_COLS) ? CC_W'(MAX_COLS) : CC_W'(cols_reg);
    assign row_lane = (state_reg == ST_RB_ROW) || (state_reg == ST_HIT_ROW);
    assign n_sel = row_lane ? CNT_W'(n_r) : CNT_W'(n_c);
    assign issue = !found_reg && (cnt_reg < n_sel);
    assign row_eff = rs_rdata[SIZE_W] ? rs_rdata[SIZE_W-1:0] : drow_reg;
    assign col_eff = cs_rdata[SIZE_W] ? cs_rdata[SIZE_W-1:0] : dcol_reg;
    assign row_pos = (act_reg == ACT_EXTENT || 32'(row_reg) > 32'(n_r))
                     ? n_r : RC_W'(row_reg);
    assign col_pos = (act_reg == ACT_EXTENT || 32'(col_reg) > 32'(n_c))
                     ? n_c : CC_W'(col_reg);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        idx_next   = idx_reg;
        pend_next  = pend_reg;
        found_next = found_reg;
        acc_next   = acc_reg;
        stale_next = stale_reg;
        hc_next    = hc_reg;
        hr_next    = hr_reg;
        rows_next  = rows_reg;
        cols_next  = cols_reg;
        drow_next  = drow_reg;
        dcol_next  = dcol_reg;
        act_next   = act_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        px_next    = px_reg;
        py_next    = py_reg;
        done_next  = 1'b0;
        cx_next    = cx_reg;
        cy_next    = cy_reg;
        cw_next    = cw_reg;
        ch_next    = ch_reg;
        hrow_next  = hrow_reg;
        hcol_next  = hcol_reg;

        rs_we    = 1'b0;
        rs_waddr = RA_W'(cnt_reg);
        rs_wdata = '0;
        rs_raddr = (state_reg == ST_BND_RD) ? RA_W'(row_reg) : RA_W'(cnt_reg);
        cs_we    = 1'b0;
        cs_waddr = CA_W'(cnt_reg);
        cs_wdata = '0;
        cs_raddr = (state_reg == ST_BND_RD) ? CA_W'(col_reg) : CA_W'(cnt_reg);
        rp_we    = 1'b0;
        rp_waddr = pend_reg ? RC_W'(idx_reg) : n_r;
        rp_wdata = RP_W'(acc_reg);
        rp_raddr = (state_reg == ST_BND_RD) ? row_pos : RC_W'(cnt_reg + 1'b1);
        cp_we    = 1'b0;
        cp_waddr = pend_reg ? CC_W'(idx_reg) : n_c;
        cp_wdata = CP_W'(acc_reg);
        cp_raddr = (state_reg == ST_BND_RD) ? col_pos : CC_W'(cnt_reg + 1'b1);

        if (wr_en)
        begin
            case (wr_index)
                REG_ROWS:   rows_next = wr_data[10:0];
                REG_COLS:   cols_next = wr_data[8:0];
                REG_ROW_SZ: drow_next = wr_data;
                REG_COL_SZ: dcol_next = wr_data;
                default:    rows_next = rows_reg;
            endcase
            stale_next = 1'b1;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                rs_we    = 32'(cnt_reg) < MAX_ROWS;
                cs_we    = 32'(cnt_reg) < MAX_COLS;
                cnt_next = cnt_reg + 1'b1;
                if (32'(cnt_reg) == MAXN - 1)
                begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (accept)
                begin
                    act_next   = action;
                    row_next   = row_index;
                    col_next   = col_index;
                    px_next    = point_x;
                    py_next    = point_y;
                    cnt_next   = '0;
                    pend_next  = 1'b0;
                    found_next = 1'b0;
                    acc_next   = '0;
                    hc_next    = '0;
                    hr_next    = '0;
                    cx_next    = '0;
                    cy_next    = '0;
                    cw_next    = '0;
                    ch_next    = '0;
                    hrow_next  = '0;
                    hcol_next  = '0;
                    case (action) inside
                        ACT_SET_ROW:
                        begin
                            done_next = 1'b1;
                            if (32'(row_index) < MAX_ROWS)
                            begin
                                rs_we      = 1'b1;
                                rs_waddr   = RA_W'(row_index);
                                rs_wdata   = {1'b1, size_value};
                                stale_next = 1'b1;
                            end
                        end
                        ACT_SET_COL:
                        begin
                            done_next = 1'b1;
                            if (32'(col_index) < MAX_COLS)
                            begin
                                cs_we      = 1'b1;
                                cs_waddr   = CA_W'(col_index);
                                cs_wdata   = {1'b1, size_value};
                                stale_next = 1'b1;
                            end
                        end
                        ACT_BOUNDS, ACT_HIT, ACT_EXTENT:
                        begin
                            state_next = stale_reg ? ST_RB_ROW : query_entry(action);
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end

            ST_RB_ROW, ST_RB_COL:
            begin
                if (issue)
                begin
                    cnt_next = cnt_reg + 1'b1;
                    idx_next = cnt_reg;
                end
                pend_next = issue;
                if (pend_reg)
                begin
                    rp_we    = row_lane;
                    cp_we    = !row_lane;
                    acc_next = acc_reg + (row_lane ? ACC_W'(row_eff) : ACC_W'(col_eff));
                end
                else if (!issue)
                begin
                    rp_we    = row_lane;
                    cp_we    = !row_lane;
                    cnt_next = '0;
                    acc_next = '0;
                    if (row_lane)
                    begin
                        state_next = ST_RB_COL;
                    end
                    else
                    begin
                        stale_next = 1'b0;
                        state_next = query_entry(act_reg);
                    end
                end
            end

            ST_BND_RD:
            begin
                state_next = ST_BND_OUT;
            end

            ST_BND_OUT:
            begin
                cx_next = 24'(cp_rdata);
                cy_next = 26'(rp_rdata);
                if (act_reg == ACT_BOUNDS)
                begin
                    cw_next = (32'(col_reg) < MAX_COLS) ? col_eff : dcol_reg;
                    ch_next = (32'(row_reg) < MAX_ROWS) ? row_eff : drow_reg;
                end
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end

            ST_HIT_COL, ST_HIT_ROW:
            begin
                if (issue)
                begin
                    cnt_next = cnt_reg + 1'b1;
                    idx_next = cnt_reg;
                end
                pend_next = issue;
                if (pend_reg && !found_reg)
                begin
                    if (row_lane)
                    begin
                        hr_next = RC_W'(idx_reg);
                        found_next = 32'(rp_rdata) > 32'(py_reg);
                    end
                    else
                    begin
                        hc_next = CC_W'(idx_reg);
                        found_next = 32'(cp_rdata) > 32'(px_reg);
                    end
                end
                if (!pend_reg && !issue)
                begin
                    cnt_next   = '0;
                    found_next = 1'b0;
                    if (row_lane)
                    begin
                        hrow_next  = 10'(hr_reg);
                        hcol_next  = 8'(hc_reg);
                        done_next  = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_HIT_ROW;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            cnt_reg   <= '0;
            idx_reg   <= '0;
            pend_reg  <= 1'b0;
            found_reg <= 1'b0;
            acc_reg   <= '0;
            stale_reg <= 1'b1;
            hc_reg    <= '0;
            hr_reg    <= '0;
            rows_reg  <= ROWS_RST;
            cols_reg  <= COLS_RST;
            drow_reg  <= ROW_SZ_RST;
            dcol_reg  <= COL_SZ_RST;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            idx_reg   <= idx_next;
            pend_reg  <= pend_next;
            found_reg <= found_next;
            acc_reg   <= acc_next;
            stale_reg <= stale_next;
            hc_reg    <= hc_next;
            hr_reg    <= hr_next;
            rows_reg  <= rows_next;
            cols_reg  <= cols_next;
            drow_reg  <= drow_next;
            dcol_reg  <= dcol_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg  <= act_next;
        row_reg  <= row_next;
        col_reg  <= col_next;
        px_reg   <= px_next;
        py_reg   <= py_next;
        cx_reg   <= cx_next;
        cy_reg   <= cy_next;
        cw_reg   <= cw_next;
        ch_reg   <= ch_next;
        hrow_reg <= hrow_next;
        hcol_reg <= hcol_next;
    end

    assign busy        = (state_reg != ST_IDLE);
    assign done        = done_reg;
    assign cell_x      = cx_reg;
    assign cell_y      = cy_reg;
    assign cell_width  = cw_reg;
    assign cell_height = ch_reg;
    assign hit_row     = hrow_reg;
    assign hit_col     = hcol_reg;

endmodule

>>> tb/variable_grid_layout_mapper_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// variable_grid_layout_mapper_tb
// A directed table of commands, then random commands in several grid
// configurations. Every result word is checked against a predictor that
// keeps its own override stores and prefix tables.
// ----------------------------------------------------------------------------
module variable_grid_layout_mapper_tb;
    import vglm_pkg::*;

    localparam int NROWS = 1024;
    localparam int NCOLS = 256;

    typedef struct packed {
        logic [23:0] x;
        logic [25:0] y;
        logic [15:0] w;
        logic [15:0] h;
        logic [9:0]  hr;
        logic [7:0]  hc;
    } layout_t;

    typedef struct {
        logic [2:0]  act;
        logic [10:0] row;
        logic [8:0]  col;
        logic [15:0] sz;
        logic [23:0] px;
        logic [25:0] py;
        bit          known;
        layout_t     res;
    } cmd_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [2:0]  action;
    logic [10:0] row_index;
    logic [8:0]  col_index;
    logic [15:0] size_value;
    logic [23:0] point_x;
    logic [25:0] point_y;
    logic        done;
    logic [23:0] cell_x;
    logic [25:0] cell_y;
    logic [15:0] cell_width;
    logic [15:0] cell_height;
    logic [9:0]  hit_row;
    logic [7:0]  hit_col;
    logic        wr_en;
    logic [1:0]  wr_index;
    logic [15:0] wr_data;

    logic [10:0] m_rows;
    logic [8:0]  m_cols;
    logic [15:0] m_row_dflt;
    logic [15:0] m_col_dflt;
    logic [15:0] m_row_sz [NROWS];
    bit          m_row_ov [NROWS];
    logic [15:0] m_col_sz [NCOLS];
    bit          m_col_ov [NCOLS];
    logic [63:0] m_row_edge [NROWS+1];
    logic [63:0] m_col_edge [NCOLS+1];

    layout_t layout_q[$];
    int      fails;
    cmd_t    dir_tbl[$];

    variable_grid_layout_mapper u_top (.*);

    initial clk = 1'b0;
    always #6 clk = ~clk;

    function automatic int rows_act();
        return (m_rows > NROWS) ? NROWS : int'(m_rows);
    endfunction

    function automatic int cols_act();
        return (m_cols > NCOLS) ? NCOLS : int'(m_cols);
    endfunction

    function automatic logic [63:0] row_h(int r);
        return (r < NROWS && m_row_ov[r]) ? 64'(m_row_sz[r]) : 64'(m_row_dflt);
    endfunction

    function automatic logic [63:0] col_w(int c);
        return (c < NCOLS && m_col_ov[c]) ? 64'(m_col_sz[c]) : 64'(m_col_dflt);
    endfunction

    function automatic void rebuild_edges();
        logic [63:0] acc;
        acc = 0;
        for (int i = 0; i < rows_act(); i++)
        begin
            m_row_edge[i] = acc;
            acc += row_h(i);
        end
        m_row_edge[rows_act()] = acc;
        acc = 0;
        for (int i = 0; i < cols_act(); i++)
        begin
            m_col_edge[i] = acc;
            acc += col_w(i);
        end
        m_col_edge[cols_act()] = acc;
    endfunction

    function automatic layout_t predict_layout(cmd_t c);
        layout_t r;
        int      n;
        r = '0;
        case (c.act)
            ACT_SET_ROW:
                if (c.row < NROWS)
                begin
                    m_row_sz[c.row] = c.sz;
                    m_row_ov[c.row] = 1'b1;
                end
            ACT_SET_COL:
                if (c.col < NCOLS)
                begin
                    m_col_sz[c.col] = c.sz;
                    m_col_ov[c.col] = 1'b1;
                end
            ACT_BOUNDS:
            begin
                rebuild_edges();
                n = cols_act();
                r.x = 24'(m_col_edge[(c.col > n) ? n : int'(c.col)]);
                n = rows_act();
                r.y = 26'(m_row_edge[(c.row > n) ? n : int'(c.row)]);
                r.w = 16'(col_w(int'(c.col)));
                r.h = 16'(row_h(int'(c.row)));
            end
            ACT_HIT:
            begin
                rebuild_edges();
                for (int i = 0; i < cols_act(); i++)
                begin
                    r.hc = 8'(i);
                    if (m_col_edge[i+1] > 64'(c.px))
                        break;
                end
                for (int i = 0; i < rows_act(); i++)
                begin
                    r.hr = 10'(i);
                    if (m_row_edge[i+1] > 64'(c.py))
                        break;
                end
            end
            ACT_EXTENT:
            begin
                rebuild_edges();
                r.x = 24'(m_col_edge[cols_act()]);
                r.y = 26'(m_row_edge[rows_act()]);
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic write_reg(reg_idx_t idx, logic [15:0] val);
        @(posedge clk);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= val;
        @(posedge clk);
        wr_en <= 1'b0;
        case (idx)
            REG_ROWS:   m_rows     = val[10:0];
            REG_COLS:   m_cols     = val[8:0];
            REG_ROW_SZ: m_row_dflt = val;
            REG_COL_SZ: m_col_dflt = val;
            default: ;
        endcase
    endtask

    task automatic issue_cmd(cmd_t c);
        layout_t p;
        start      <= 1'b1;
        action     <= c.act;
        row_index  <= c.row;
        col_index  <= c.col;
        size_value <= c.sz;
        point_x    <= c.px;
        point_y    <= c.py;
        do
            @(posedge clk);
        while (busy);
        p = predict_layout(c);
        if (c.known && p != c.res)
            begin
                $error("table row disagrees with predictor");
                fails++;
            end
        layout_q.push_back(p);
        if ($urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(0, 9) == 0 ? $urandom_range(5, 60)
                                               : $urandom_range(1, 3))
                @(posedge clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        while (layout_q.size() != 0)
            @(posedge clk);
        repeat (2200) @(posedge clk);
    endtask

    function automatic cmd_t mk(logic [2:0] a, logic [10:0] r, logic [8:0] c,
                                logic [15:0] s, logic [23:0] x, logic [25:0] y);
        cmd_t t;
        t.act = a; t.row = r; t.col = c; t.sz = s; t.px = x; t.py = y;
        t.known = 1'b0; t.res = '0;
        return t;
    endfunction

    function automatic cmd_t rand_cmd();
        cmd_t t;
        int   k;
        k = $urandom_range(0, 19);
        t = mk(3'(ACT_BOUNDS), 11'd0, 9'd0, 16'($urandom), 24'($urandom),
               26'($urandom));
        if (k < 4)       t.act = ACT_SET_ROW;
        else if (k < 7)  t.act = ACT_SET_COL;
        else if (k < 11) t.act = ACT_BOUNDS;
        else if (k < 16) t.act = ACT_HIT;
        else if (k < 18) t.act = ACT_EXTENT;
        else             t.act = 3'($urandom_range(5, 7));
        t.row = ($urandom_range(0, 7) == 0) ? 11'($urandom) : 11'($urandom_range(0, 130));
        t.col = ($urandom_range(0, 7) == 0) ? 9'($urandom) : 9'($urandom_range(0, 40));
        if ($urandom_range(0, 1))
        begin
            t.px = 24'($urandom_range(0, 60000));
            t.py = 26'($urandom_range(0, 60000));
        end
        return t;
    endfunction

    always @(posedge clk)
    begin
        layout_t got, exp_l;
        if (rst_n && done)
        begin
            got = '{cell_x, cell_y, cell_width, cell_height, hit_row, hit_col};
            if (layout_q.size() == 0)
            begin
                $error("unexpected result word");
                fails++;
            end
            else
            begin
                exp_l = layout_q.pop_front();
                if (got.x != exp_l.x)
                begin
                    $error("cell_x exp %0h got %0h", exp_l.x, got.x); fails++;
                end
                if (got.y != exp_l.y)
                begin
                    $error("cell_y exp %0h got %0h", exp_l.y, got.y); fails++;
                end
                if (got.w != exp_l.w)
                begin
                    $error("cell_width exp %0h got %0h", exp_l.w, got.w); fails++;
                end
                if (got.h != exp_l.h)
                begin
                    $error("cell_height exp %0h got %0h", exp_l.h, got.h); fails++;
                end
                if (got.hr != exp_l.hr)
                begin
                    $error("hit_row exp %0h got %0h", exp_l.hr, got.hr); fails++;
                end
                if (got.hc != exp_l.hc)
                begin
                    $error("hit_col exp %0h got %0h", exp_l.hc, got.hc); fails++;
                end
            end
        end
    end

    initial
    begin
        #80ms;
        $display("** variable_grid_layout_mapper: FAILED **");
        $finish;
    end

    initial
    begin
        cmd_t t;
        fails = 0;
        rst_n = 1'b0; start = 1'b0; action = '0; row_index = '0; col_index = '0;
        size_value = '0; point_x = '0; point_y = '0;
        wr_en = 1'b0; wr_index = '0; wr_data = '0;
        m_rows = ROWS_RST; m_cols = COLS_RST;
        m_row_dflt = ROW_SZ_RST; m_col_dflt = COL_SZ_RST;
        for (int i = 0; i < NROWS; i++) m_row_ov[i] = 1'b0;
        for (int i = 0; i < NCOLS; i++) m_col_ov[i] = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // after reset: 26 x 1280 wide, 100 x 384 high
        t = mk(3'(ACT_EXTENT), 0, 0, 0, 0, 0);
        t.known = 1; t.res = '{24'd33280, 26'd38400, 16'd0, 16'd0, 10'd0, 8'd0};
        dir_tbl.push_back(t);
        t = mk(3'(ACT_BOUNDS), 11'd2047, 9'd511, 0, 0, 0);
        t.known = 1;
        t.res = '{24'd33280, 26'd38400, 16'd1280, 16'd384, 10'd0, 8'd0};
        dir_tbl.push_back(t);
        t = mk(3'(ACT_HIT), 0, 0, 0, 24'hFFFFFF, 26'h3FFFFFF);
        t.known = 1; t.res = '{'0, '0, '0, '0, 10'd99, 8'd25};
        dir_tbl.push_back(t);
        t = mk(3'(ACT_HIT), 0, 0, 0, 0, 0);
        t.known = 1; t.res = '0;
        dir_tbl.push_back(t);
        t = mk(3'd7, 11'h7FF, 9'h1FF, 16'hFFFF, 24'hFFFFFF, 26'h3FFFFFF);
        t.known = 1; t.res = '0;
        dir_tbl.push_back(t);
        t = mk(3'd5, 0, 0, 0, 0, 0); t.known = 1; dir_tbl.push_back(t);
        t = mk(3'd6, 0, 0, 0, 0, 0); t.known = 1; dir_tbl.push_back(t);
        t = mk(3'(ACT_SET_ROW), 11'd1024, 0, 16'hFFFF, 0, 0); t.known = 1;
        dir_tbl.push_back(t);
        t = mk(3'(ACT_SET_COL), 0, 9'd256, 16'hFFFF, 0, 0); t.known = 1;
        dir_tbl.push_back(t);
        t = mk(3'(ACT_SET_ROW), 11'd1023, 0, 16'hFFFF, 0, 0); t.known = 1;
        dir_tbl.push_back(t);
        t = mk(3'(ACT_SET_COL), 0, 9'd255, 16'hFFFF, 0, 0); t.known = 1;
        dir_tbl.push_back(t);
        t = mk(3'(ACT_SET_ROW), 11'd0, 0, 16'd0, 0, 0); t.known = 1;
        dir_tbl.push_back(t);
        t = mk(3'(ACT_SET_COL), 0, 9'd3, 16'd100, 0, 0); t.known = 1;
        dir_tbl.push_back(t);
        dir_tbl.push_back(mk(3'(ACT_BOUNDS), 11'd1023, 9'd255, 0, 0, 0));
        dir_tbl.push_back(mk(3'(ACT_BOUNDS), 11'd0, 9'd3, 0, 0, 0));
        dir_tbl.push_back(mk(3'(ACT_BOUNDS), 11'd100, 9'd26, 0, 0, 0));
        dir_tbl.push_back(mk(3'(ACT_HIT), 0, 0, 0, 24'd3940, 26'd383));
        dir_tbl.push_back(mk(3'(ACT_HIT), 0, 0, 0, 24'd3939, 26'd384));
        dir_tbl.push_back(mk(3'(ACT_EXTENT), 0, 0, 0, 0, 0));

        foreach (dir_tbl[i])
            issue_cmd(dir_tbl[i]);
        drain();

        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0:
                begin
                    write_reg(REG_ROWS, 16'd0); write_reg(REG_COLS, 16'd0);
                end
                1:
                begin
                    write_reg(REG_ROWS, 16'h7FF); write_reg(REG_COLS, 16'h1FF);
                    write_reg(REG_ROW_SZ, 16'hFFFF); write_reg(REG_COL_SZ, 16'hFFFF);
                end
                2:
                begin
                    write_reg(REG_ROWS, 16'd1024); write_reg(REG_COLS, 16'd256);
                    write_reg(REG_ROW_SZ, 16'd0); write_reg(REG_COL_SZ, 16'd0);
                end
                default:
                begin
                    write_reg(REG_ROWS, 16'($urandom_range(1, 130)));
                    write_reg(REG_COLS, 16'($urandom_range(1, 40)));
                    write_reg(REG_ROW_SZ, $urandom_range(0, 1) ? 16'($urandom)
                                                               : 16'($urandom_range(0, 800)));
                    write_reg(REG_COL_SZ, $urandom_range(0, 1) ? 16'($urandom)
                                                               : 16'($urandom_range(0, 2000)));
                end
            endcase
            for (int i = 0; i < (ph < 3 ? 40 : 110); i++)
                issue_cmd(rand_cmd());
            drain();
        end

        if (fails == 0)
            $display("** variable_grid_layout_mapper: PASSED **");
        else
            $display("** variable_grid_layout_mapper: FAILED **");
        $finish;
    end

endmodule
